### rtl/wdt_pkg.sv
// package: types, constants and register codes of the windowed detection trigger
package wdt_pkg;

	localparam int WINDOW_MAX_DEF = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_SIZE       = 3'd0,
		REG_MIN_HIGH_COUNT    = 3'd1,
		REG_FRAME_THRESHOLD   = 3'd2,
		REG_AVERAGE_THRESHOLD = 3'd3,
		REG_DETECT_HOLDOFF    = 3'd4,
		REG_STARTUP_HOLD_MS   = 3'd5
	} reg_idx_t;

	localparam logic ACT_FRAME   = 1'b0;
	localparam logic ACT_RESTART = 1'b1;

	localparam logic [4:0]  RST_WINDOW_SIZE       = 5'd10;
	localparam logic [4:0]  RST_MIN_HIGH_COUNT    = 5'd6;
	localparam logic [7:0]  RST_FRAME_THRESHOLD   = 8'd128;
	localparam logic [7:0]  RST_AVERAGE_THRESHOLD = 8'd128;
	localparam logic [15:0] RST_DETECT_HOLDOFF    = 16'd1500;
	localparam logic [15:0] RST_STARTUP_HOLD_MS   = 16'd3000;

	typedef struct packed {
		logic        action;
		logic [7:0]  probability;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic        detected;
		logic        window_full;
		logic [11:0] window_sum;
		logic [4:0]  high_count;
	} out_item_t;

	typedef struct packed {
		logic [4:0]  window_size;
		logic [4:0]  min_high_count;
		logic [7:0]  frame_threshold;
		logic [7:0]  average_threshold;
		logic [15:0] detect_holdoff;
		logic [15:0] startup_hold_ms;
		logic        win_clear;
	} cfg_t;

endpackage

### rtl/wdt_ram.sv
// generic single-write, single-read ram with registered read data
module wdt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/wdt_cfg.sv
// configuration register file and window clear request
module wdt_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [wdt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wdt_pkg::CFG_DATA_W-1:0]     cfg_data,
	output wdt_pkg::cfg_t                      cfg
);

	logic        wr;
	logic [4:0]  window_size_q;
	logic [4:0]  min_high_q;
	logic [7:0]  frame_thr_q;
	logic [7:0]  avg_thr_q;
	logic [15:0] cooldown_q;
	logic [15:0] startup_q;
	logic        win_clear;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid && cfg_ready;

	always_comb begin
		win_clear = 1'b0;
		if (wr) begin
			unique case (cfg_index)
				wdt_pkg::REG_WINDOW_SIZE,
				wdt_pkg::REG_FRAME_THRESHOLD: win_clear = 1'b1;
				default:                      win_clear = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= wdt_pkg::RST_WINDOW_SIZE;
			min_high_q    <= wdt_pkg::RST_MIN_HIGH_COUNT;
			frame_thr_q   <= wdt_pkg::RST_FRAME_THRESHOLD;
			avg_thr_q     <= wdt_pkg::RST_AVERAGE_THRESHOLD;
			cooldown_q    <= wdt_pkg::RST_DETECT_HOLDOFF;
			startup_q     <= wdt_pkg::RST_STARTUP_HOLD_MS;
		end else if (wr) begin
			unique case (cfg_index)
				wdt_pkg::REG_WINDOW_SIZE:       window_size_q <= cfg_data[4:0];
				wdt_pkg::REG_MIN_HIGH_COUNT:    min_high_q    <= cfg_data[4:0];
				wdt_pkg::REG_FRAME_THRESHOLD:   frame_thr_q   <= cfg_data[7:0];
				wdt_pkg::REG_AVERAGE_THRESHOLD: avg_thr_q     <= cfg_data[7:0];
				wdt_pkg::REG_DETECT_HOLDOFF:    cooldown_q    <= cfg_data;
				wdt_pkg::REG_STARTUP_HOLD_MS:   startup_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.window_size       = window_size_q;
		cfg.min_high_count    = min_high_q;
		cfg.frame_threshold   = frame_thr_q;
		cfg.average_threshold = avg_thr_q;
		cfg.detect_holdoff    = cooldown_q;
		cfg.startup_hold_ms   = startup_q;
		cfg.win_clear         = win_clear;
	end

endmodule

### rtl/wdt_core.sv
// input register, window state, sum/count update, trigger decision and result register
module wdt_core #(
	parameter int WINDOW_MAX = wdt_pkg::WINDOW_MAX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  wdt_pkg::cfg_t      cfg,
	input  logic               in_valid,
	output logic               in_stall,
	input  wdt_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output wdt_pkg::out_item_t out_data
);

	localparam int PTR_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int SIZE_W = $clog2(WINDOW_MAX + 1);
	localparam int SUM_W  = $clog2(WINDOW_MAX * 255 + 1);
	localparam int PROD_W = 8 + SIZE_W;

	// input stage
	logic               s1_valid_q;
	wdt_pkg::in_item_t  s1_item_s1;
	logic               s1_go;
	logic               in_ok;

	// result stage
	logic               out_valid_q;
	wdt_pkg::out_item_t out_item_q;
	wdt_pkg::out_item_t out_d;

	// window state
	logic [PTR_W-1:0]   wp_q, wp_d;
	logic               full_q, full_d;
	logic [SUM_W-1:0]   sum_q, sum_d;
	logic [SIZE_W-1:0]  high_q, high_d;
	logic [31:0]        hold_q, hold_d;

	// ring read path with write bypass
	logic               we;
	logic [7:0]         ram_rdata;
	logic               byp_q;
	logic [7:0]         byp_data_q;
	logic [7:0]         rd_val;

	logic               frame, restart;
	logic [SIZE_W-1:0]  size;
	logic [7:0]         old;
	logic [SUM_W-1:0]   sum_new;
	logic [SIZE_W-1:0]  high_new;
	logic               dec, inc;
	logic [PTR_W:0]     wp_inc;
	logic               wrap;
	logic               full_new;
	logic [31:0]        diff;
	logic [PROD_W-1:0]  prod;
	logic               fire;

	assign in_stall = s1_valid_q && out_valid_q && out_stall;
	assign in_ok    = in_valid && !in_stall;
	assign s1_go    = s1_valid_q && !(out_valid_q && out_stall);

	assign frame   = s1_go && (s1_item_s1.action == wdt_pkg::ACT_FRAME);
	assign restart = s1_go && (s1_item_s1.action == wdt_pkg::ACT_RESTART);

	always_comb begin
		if (cfg.window_size == 5'd0) begin
			size = SIZE_W'(1);
		end else if (32'(cfg.window_size) > 32'(WINDOW_MAX)) begin
			size = SIZE_W'(WINDOW_MAX);
		end else begin
			size = SIZE_W'(cfg.window_size);
		end
	end

	assign rd_val   = byp_q ? byp_data_q : ram_rdata;
	assign old      = full_q ? rd_val : 8'd0;
	assign sum_new  = sum_q - SUM_W'(old) + SUM_W'(s1_item_s1.probability);
	assign dec      = full_q && (old >= cfg.frame_threshold);
	assign inc      = s1_item_s1.probability >= cfg.frame_threshold;
	assign high_new = high_q - SIZE_W'(dec) + SIZE_W'(inc);
	assign wp_inc   = {1'b0, wp_q} + (PTR_W + 1)'(1);
	assign wrap     = 32'(wp_inc) >= 32'(size);
	assign full_new = full_q || wrap;
	assign diff     = s1_item_s1.now_ms - hold_q;
	assign prod     = PROD_W'(cfg.average_threshold) * PROD_W'(size);
	assign fire     = frame && full_new && !diff[31]
		&& (32'(sum_new) >= 32'(prod))
		&& (32'(high_new) >= 32'(cfg.min_high_count));

	always_comb begin
		wp_d   = wp_q;
		full_d = full_q;
		sum_d  = sum_q;
		high_d = high_q;
		hold_d = hold_q;
		if (cfg.win_clear) begin
			wp_d   = '0;
			full_d = 1'b0;
			sum_d  = '0;
			high_d = '0;
		end else if (restart) begin
			wp_d   = '0;
			full_d = 1'b0;
			sum_d  = '0;
			high_d = '0;
			hold_d = s1_item_s1.now_ms + 32'(cfg.startup_hold_ms);
		end else if (frame) begin
			if (fire) begin
				wp_d   = '0;
				full_d = 1'b0;
				sum_d  = '0;
				high_d = '0;
				hold_d = s1_item_s1.now_ms + 32'(cfg.detect_holdoff);
			end else begin
				wp_d   = wrap ? '0 : wp_inc[PTR_W-1:0];
				full_d = full_new;
				sum_d  = sum_new;
				high_d = high_new;
			end
		end
	end

	always_comb begin
		out_d.detected    = fire;
		out_d.window_full = frame && full_new;
		out_d.window_sum  = (frame && full_new) ? 12'(sum_new) : 12'd0;
		out_d.high_count  = frame ? 5'(high_new) : 5'd0;
	end

	assign we = frame;

	wdt_ram #(
		.WIDTH (8),
		.DEPTH (WINDOW_MAX)
	) u_ring (
		.clk   (clk),
		.we    (we),
		.waddr (wp_q),
		.wdata (s1_item_s1.probability),
		.raddr (wp_d),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			wp_q        <= '0;
			full_q      <= 1'b0;
			sum_q       <= '0;
			high_q      <= '0;
			hold_q      <= '0;
			byp_q       <= 1'b0;
		end else begin
			if (in_ok) begin
				s1_valid_q <= 1'b1;
			end else if (s1_go) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			wp_q   <= wp_d;
			full_q <= full_d;
			sum_q  <= sum_d;
			high_q <= high_d;
			hold_q <= hold_d;
			byp_q  <= we && (wp_q == wp_d);
		end
	end

	always_ff @(posedge clk) begin
		if (in_ok) begin
			s1_item_s1 <= in_data;
		end
		if (s1_go) begin
			out_item_q <= out_d;
		end
		byp_data_q <= s1_item_s1.probability;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_item_q;

endmodule

### rtl/windowed_detection_trigger_unit.sv
// top level of the windowed detection trigger
// Each transaction on the input channel is either a frame (a Q0.8 probability with a
// millisecond timestamp) or a restart, and produces exactly one result transaction.
// The result is offered from the result register once its item has passed the input
// register, and a new item is taken every cycle unless the result side stalls;
// the window sum and high-frame count
// are kept running, so the only per-item work is one ring read, one add/subtract and
// a small threshold multiply. The ring lives in a RAM of WINDOW_MAX entries read
// ahead at the next write position; it needs no clearing pass, since entries
// are only used once a full window has been written. Configuration writes are
// always ready; writing window_size or frame_threshold clears the window.
module windowed_detection_trigger_unit #(
	parameter int WINDOW_MAX = wdt_pkg::WINDOW_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  wdt_pkg::in_item_t              in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output wdt_pkg::out_item_t             out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [wdt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wdt_pkg::CFG_DATA_W-1:0] cfg_data
);

	wdt_pkg::cfg_t cfg;

	wdt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	wdt_core #(
		.WINDOW_MAX (WINDOW_MAX)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

### rtl/wdt_checker.sv
// port-level checker for the windowed detection trigger, bound to the top level
module wdt_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input wdt_pkg::out_item_t             out_data
);

	// with no result waiting the input side never backs up
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty result register");

	// a stalled result transaction stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// a detection only fires on a full window
	a_fire_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.detected |-> out_data.window_full)
		else $error("detection without full window");

	// a partial window reports no sum
	a_partial_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.window_full |-> out_data.window_sum == 12'd0)
		else $error("nonzero sum on partial window");

endmodule

bind windowed_detection_trigger_unit wdt_checker u_wdt_checker (.*);

### dv/windowed_detection_trigger_unit_test.sv
// testbench of the windowed detection trigger: predicted results checked on every output transaction
module windowed_detection_trigger_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RING_DEPTH = wdt_pkg::WINDOW_MAX_DEF;
	localparam int IDX_W = wdt_pkg::CFG_IDX_W;
	localparam int DATA_W = wdt_pkg::CFG_DATA_W;
	localparam logic [IDX_W-1:0] IDX_SPARE_A = 3'd6;
	localparam logic [IDX_W-1:0] IDX_SPARE_B = 3'd7;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_LIMIT = 2000;
	localparam int REPORT_LIMIT = 10;
	localparam int NOISE_PCT = 15;

	// window, min high, frame thr, average thr, cooldown, startup hold
	localparam int CORNER_CFG [7][6] = '{
		'{0, 0, 0, 0, 0, 0},
		'{1, 1, 255, 255, 65535, 65535},
		'{16, 16, 255, 255, 0, 0},
		'{17, 31, 128, 100, 1500, 3000},
		'{31, 0, 0, 0, 65535, 0},
		'{16, 9, 90, 120, 0, 65535},
		'{2, 2, 200, 230, 300, 100}
	};

	typedef enum int {RCV_OPEN, RCV_RANDOM, RCV_PATTERN} rcv_style_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	wdt_pkg::in_item_t          in_data = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	wdt_pkg::out_item_t         out_data;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [IDX_W-1:0]           cfg_index = '0;
	logic [DATA_W-1:0]          cfg_data = '0;

	// predictor copy of registers and window state
	logic [4:0]  set_window;
	logic [4:0]  set_min_high;
	logic [7:0]  set_frame_thr;
	logic [7:0]  set_avg_thr;
	logic [15:0] set_cooldown;
	logic [15:0] set_startup;
	logic [7:0]  ring_prob [RING_DEPTH];
	int          ring_pos;
	int          ring_sum;
	int          ring_high;
	bit          ring_filled;
	logic [31:0] hold_until_ms;

	wdt_pkg::out_item_t trigger_results_due [$];
	wdt_pkg::out_item_t due;

	int frames_sent = 0;
	int restarts_sent = 0;
	int detections_due = 0;
	int reg_writes = 0;
	int settings_tried = 0;
	int input_stall_cycles = 0;
	int mismatches = 0;

	int          gap_max = 0;
	int          burst_left = 0;
	int          hot_left = 0;
	bit          run_hot = 1'b0;
	logic [31:0] clock_ms = '0;

	rcv_style_t rcv_style = RCV_OPEN;
	int         rcv_pct = 0;
	int         rcv_period = 1;
	int         rcv_duty = 0;
	int         rcv_cycle = 0;
	bit         rcv_stall = 1'b0;
	logic       receiver_held = 1'b0;
	event       hold_off_start;

	windowed_detection_trigger_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5ms;
		$display("timeout with %0d results outstanding", trigger_results_due.size());
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int window_len();
		if (set_window == 0) return 1;
		if (set_window > RING_DEPTH) return RING_DEPTH;
		return set_window;
	endfunction

	function automatic void clear_window();
		foreach (ring_prob[i]) ring_prob[i] = '0;
		ring_pos = 0;
		ring_filled = 1'b0;
		ring_sum = 0;
		ring_high = 0;
	endfunction

	function automatic void reset_predictor();
		set_window = wdt_pkg::RST_WINDOW_SIZE;
		set_min_high = wdt_pkg::RST_MIN_HIGH_COUNT;
		set_frame_thr = wdt_pkg::RST_FRAME_THRESHOLD;
		set_avg_thr = wdt_pkg::RST_AVERAGE_THRESHOLD;
		set_cooldown = wdt_pkg::RST_DETECT_HOLDOFF;
		set_startup = wdt_pkg::RST_STARTUP_HOLD_MS;
		clear_window();
		hold_until_ms = '0;
	endfunction

	function automatic wdt_pkg::out_item_t predict_trigger(wdt_pkg::in_item_t item);
		wdt_pkg::out_item_t res;
		int                 len;
		int                 old;
		logic [31:0]        since_hold;
		bit                 fire;
		res = '0;
		len = window_len();
		if (item.action == wdt_pkg::ACT_RESTART) begin
			clear_window();
			hold_until_ms = item.now_ms + 32'(set_startup);
			return res;
		end
		if (ring_pos >= len) ring_pos = 0;
		old = ring_prob[ring_pos];
		ring_sum = ring_sum - old + item.probability;
		if (ring_filled && old >= set_frame_thr) ring_high--;
		if (item.probability >= set_frame_thr) ring_high++;
		ring_prob[ring_pos] = item.probability;
		ring_pos++;
		if (ring_pos >= len) begin
			ring_pos = 0;
			ring_filled = 1'b1;
		end
		// wrap-safe: signed difference to the end of the hold
		since_hold = item.now_ms - hold_until_ms;
		fire = ring_filled && !since_hold[31] && ring_sum >= set_avg_thr * len
			&& ring_high >= set_min_high;
		res.detected = fire;
		res.window_full = ring_filled;
		res.window_sum = ring_filled ? 12'(ring_sum) : 12'd0;
		res.high_count = 5'(ring_high);
		if (fire) begin
			clear_window();
			hold_until_ms = item.now_ms + 32'(set_cooldown);
		end
		return res;
	endfunction

	always @(posedge clk) begin
		rcv_cycle++;
		case (rcv_style)
			RCV_OPEN: rcv_stall = 1'b0;
			RCV_RANDOM: rcv_stall = ($urandom_range(0, 99) < rcv_pct);
			default: rcv_stall = ((rcv_cycle % rcv_period) < rcv_duty);
		endcase
		out_stall <= receiver_held || rcv_stall;
	end

	// long receiver hold-off, counted here
	initial forever begin
		@(hold_off_start);
		@(posedge clk);
		receiver_held <= 1'b1;
		repeat (HOLD_OFF_CYCLES) @(posedge clk);
		receiver_held <= 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_stall) input_stall_cycles++;
			if (out_valid && !out_stall) begin
				if (trigger_results_due.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: result with none expected: %p", $time, out_data);
				end else begin
					due = trigger_results_due.pop_front();
					if (out_data.detected !== due.detected
							|| out_data.window_full !== due.window_full
							|| out_data.window_sum !== due.window_sum
							|| out_data.high_count !== due.high_count) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT) begin
							$display("%0t: mismatch exp det %0d full %0d sum %0d high %0d",
								$time, due.detected, due.window_full,
								due.window_sum, due.high_count);
							$display("    got det %0d full %0d sum %0d high %0d",
								out_data.detected, out_data.window_full,
								out_data.window_sum, out_data.high_count);
						end
					end
				end
			end
		end
	end

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (trigger_results_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_item(logic act, logic [7:0] prob, logic [31:0] now);
		wdt_pkg::in_item_t  item;
		wdt_pkg::out_item_t exp_res;
		int                 gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item.action = act;
		item.probability = prob;
		item.now_ms = now;
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (!(in_valid && !in_stall));
		exp_res = predict_trigger(item);
		if (exp_res.detected) detections_due++;
		trigger_results_due.push_back(exp_res);
		if (act == wdt_pkg::ACT_RESTART) restarts_sent++;
		else frames_sent++;
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		case (idx)
			wdt_pkg::REG_WINDOW_SIZE: begin
				set_window = value[4:0];
				clear_window();
			end
			wdt_pkg::REG_MIN_HIGH_COUNT: set_min_high = value[4:0];
			wdt_pkg::REG_FRAME_THRESHOLD: begin
				set_frame_thr = value[7:0];
				clear_window();
			end
			wdt_pkg::REG_AVERAGE_THRESHOLD: set_avg_thr = value[7:0];
			wdt_pkg::REG_DETECT_HOLDOFF: set_cooldown = value;
			wdt_pkg::REG_STARTUP_HOLD_MS: set_startup = value;
			default: ;
		endcase
		reg_writes++;
	endtask

	// unused upper bits of the register data get random values
	function automatic logic [DATA_W-1:0] with_junk(int value, int width);
		return DATA_W'(value) | (DATA_W'($urandom) << width);
	endfunction

	task automatic apply_settings(int win, int min_high, int frame_thr, int avg_thr,
			int cooldown, int startup);
		write_reg(wdt_pkg::REG_WINDOW_SIZE, with_junk(win, 5));
		write_reg(wdt_pkg::REG_MIN_HIGH_COUNT, with_junk(min_high, 5));
		write_reg(wdt_pkg::REG_FRAME_THRESHOLD, with_junk(frame_thr, 8));
		write_reg(wdt_pkg::REG_AVERAGE_THRESHOLD, with_junk(avg_thr, 8));
		write_reg(wdt_pkg::REG_DETECT_HOLDOFF, with_junk(cooldown, 16));
		write_reg(wdt_pkg::REG_STARTUP_HOLD_MS, with_junk(startup, 16));
		settings_tried++;
	endtask

	task automatic set_idling(int style);
		case (style)
			0: begin
				gap_max = 0;
				rcv_style = RCV_OPEN;
			end
			1: begin
				gap_max = 6;
				rcv_style = RCV_RANDOM;
				rcv_pct = 30;
			end
			2: begin
				gap_max = 12;
				rcv_style = RCV_PATTERN;
				rcv_period = 7;
				rcv_duty = 4;
			end
			default: begin
				gap_max = 3;
				rcv_style = RCV_RANDOM;
				rcv_pct = 60;
			end
		endcase
	endtask

	// random runs alternate with runs of high frames so that windows fill and fire, some noise
	task automatic send_random(bit noisy);
		logic       act;
		logic [7:0] prob;
		if ($urandom_range(0, 99) < 3) clock_ms = $urandom;
		else clock_ms += $urandom_range(0, 400);
		act = ($urandom_range(0, 99) < (noisy ? 15 : 3)) ? wdt_pkg::ACT_RESTART
			: wdt_pkg::ACT_FRAME;
		if (hot_left == 0) begin
			hot_left = $urandom_range(3, 20);
			run_hot = $urandom_range(0, 1);
		end
		hot_left--;
		if (noisy || !run_hot) prob = $urandom_range(0, 255);
		else prob = $urandom_range(set_frame_thr, 255);
		send_item(act, prob, clock_ms);
	endtask

	task automatic run_traffic(int count);
		repeat (count) send_random($urandom_range(0, 99) < NOISE_PCT);
	endtask

	task automatic test_hold_after_reset();
		set_idling(0);
		repeat (10) send_item(wdt_pkg::ACT_FRAME, 8'd255, 32'h8000_0000);
		send_item(wdt_pkg::ACT_FRAME, 8'd255, 32'hFFFF_FFFF);
		send_item(wdt_pkg::ACT_FRAME, 8'd255, 32'h0000_0000);
	endtask

	task automatic test_reset_defaults();
		set_idling(1);
		clock_ms = 32'd2000;
		run_traffic(150);
	endtask

	task automatic test_directed_cases();
		set_idling(2);
		write_reg(wdt_pkg::REG_WINDOW_SIZE, 16'd3);
		write_reg(wdt_pkg::REG_MIN_HIGH_COUNT, 16'd2);
		// hold end wraps past zero
		send_item(wdt_pkg::ACT_RESTART, 8'hFF, 32'hFFFF_FC00);
		send_item(wdt_pkg::ACT_FRAME, 8'd128, 32'hFFFF_FE00);
		send_item(wdt_pkg::ACT_FRAME, 8'd128, 32'hFFFF_FFFF);
		send_item(wdt_pkg::ACT_FRAME, 8'd128, 32'h0000_0010);
		send_item(wdt_pkg::ACT_FRAME, 8'd127, 32'd1975);
		send_item(wdt_pkg::ACT_FRAME, 8'd255, 32'd1976);
		send_item(wdt_pkg::ACT_FRAME, 8'd0, 32'd2000);
		send_item(wdt_pkg::ACT_FRAME, 8'd255, 32'd2100);
		send_item(wdt_pkg::ACT_FRAME, 8'd255, 32'd3475);
		send_item(wdt_pkg::ACT_FRAME, 8'd255, 32'd3476);
		// partial window dropped by threshold write
		send_item(wdt_pkg::ACT_FRAME, 8'd200, 32'd4000);
		write_reg(wdt_pkg::REG_FRAME_THRESHOLD, 16'd0);
		write_reg(wdt_pkg::REG_AVERAGE_THRESHOLD, 16'd0);
		repeat (3) send_item(wdt_pkg::ACT_FRAME, 8'd0, 32'd5000);
	endtask

	task automatic test_register_extremes();
		foreach (CORNER_CFG[i]) begin
			apply_settings(CORNER_CFG[i][0], CORNER_CFG[i][1], CORNER_CFG[i][2],
				CORNER_CFG[i][3], CORNER_CFG[i][4], CORNER_CFG[i][5]);
			set_idling($urandom_range(0, 3));
			clock_ms = $urandom;
			run_traffic(60);
		end
		write_reg(IDX_SPARE_A, 16'($urandom));
		write_reg(IDX_SPARE_B, 16'($urandom));
		run_traffic(40);
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < 4; phase++) begin
			apply_settings(($urandom_range(0, 99) < 80) ? $urandom_range(1, 16)
					: $urandom_range(0, 31),
				$urandom_range(0, 10), $urandom_range(0, 255), $urandom_range(0, 200),
				$urandom_range(0, 3000), $urandom_range(0, 5000));
			set_idling(phase);
			run_traffic(250);
		end
	endtask

	task automatic test_backpressure();
		set_idling(0);
		repeat (2) begin
			-> hold_off_start;
			run_traffic(150);
		end
	endtask

	initial begin
		int waited;
		reset_predictor();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_hold_after_reset();
		test_reset_defaults();
		test_directed_cases();
		test_register_extremes();
		test_random_traffic();
		test_backpressure();
		in_valid <= 1'b0;
		waited = 0;
		while (trigger_results_due.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (trigger_results_due.size() != 0) begin
			mismatches += trigger_results_due.size();
			$display("%0d expected results never arrived", trigger_results_due.size());
		end
		$display("covered %0d frames and %0d restarts over %0d register settings (%0d writes)",
			frames_sent, restarts_sent, settings_tried, reg_writes);
		$display("%0d detections expected, input held back on %0d cycles, %0d mismatches",
			detections_due, input_stall_cycles, mismatches);
		if (mismatches == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

endmodule
